@@ rtl/ixh_pkg.sv @@
// Shared types and codes for the indexed max-heap.
package ixh_pkg;

    localparam int ID_W  = 10;
    localparam int KEY_W = 32;
    localparam int OCC_W = 11;
    localparam int ST_W  = 3;
    localparam int OP_W  = 2;

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
    localparam logic [ST_W-1:0] ST_ABSENT  = 3'd3;
    localparam logic [ST_W-1:0] ST_PRESENT = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [ID_W-1:0]         item_id;
        logic signed [KEY_W-1:0] priority_req;
    } t_in_beat;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic [ID_W-1:0]         served_id;
        logic signed [KEY_W-1:0] served_key;
        logic [OCC_W-1:0]        occupancy;
    } t_out_beat;

    // one heap slot: id with its key kept alongside
    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [KEY_W-1:0] key;
    } t_node;

endpackage

@@ rtl/indexed_max_heap.sv @@
// Indexed binary max-heap of ids keyed by signed Q16.16 priority. One operation at a
// time: an op is taken, worked in the heap and slot-table RAMs (one registered read
// port each), and one result beat is returned. Push climbs levels; pop and remove
// descend levels (remove may climb instead), with at most log2(CAPACITY) levels; each
// level reads the RAMs, compares and writes back. After reset a clearing pass marks
// every id absent; no op is taken until it ends. A waiting result does not block the
// next op from being taken.
module indexed_max_heap #(
    parameter int ID_COUNT = 1024,
    parameter int CAPACITY = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ixh_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ixh_pkg::t_out_beat o_out_data
);
    import ixh_pkg::*;

    localparam int IW = $clog2(ID_COUNT);
    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + 1;
    localparam int PW = SW + 1;
    localparam int NW = ID_W + KEY_W;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DEC, S_FA, S_FB, S_DC1, S_DC2, S_DCMP,
        S_UP, S_UCMP, S_WR, S_RESP
    } t_state;

    t_state                  r_state;
    logic [IW-1:0]           r_clr;
    logic [OP_W-1:0]         r_op;
    logic [ID_W-1:0]         r_id;
    logic signed [KEY_W-1:0] r_key;
    logic [CW-1:0]           r_count;
    logic [SW-1:0]           r_s;
    t_node                   r_elem;
    t_node                   r_c1;
    logic                    r_has2;
    logic                    r_moved;
    logic [ST_W-1:0]         r_status;
    logic [ID_W-1:0]         r_sid;
    logic signed [KEY_W-1:0] r_skey;
    logic                    r_ov;
    t_out_beat               r_out;

    // memory ports
    logic          heap_we;
    logic [SW-1:0] heap_wa, heap_ra;
    t_node         heap_wd, heap_rd;
    logic [NW-1:0] heap_q;
    logic          pos_we;
    logic [IW-1:0] pos_wa, pos_ra;
    logic [PW-1:0] pos_wd, pos_rd;

    ixh_ram #(.DEPTH(CAPACITY), .WIDTH(NW)) u_heap (
        .i_clk(i_clk), .i_we(heap_we), .i_wa(heap_wa), .i_wd(heap_wd),
        .i_ra(heap_ra), .o_rd(heap_q)
    );
    ixh_ram #(.DEPTH(ID_COUNT), .WIDTH(PW)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_wa(pos_wa), .i_wd(pos_wd),
        .i_ra(pos_ra), .o_rd(pos_rd)
    );
    assign heap_rd = t_node'(heap_q);

    logic          id_ok, present;
    logic [SW-1:0] slot, last_s, par_s, c1_s, c2_s, best_idx;
    logic [CW-1:0] last;
    logic [XW-1:0] c1_x, c2_x, lim_x;
    logic          best_is2, down_swap, up_swap;
    t_node         best;
    t_state        down_end;

    always_comb begin
        id_ok    = 32'(r_id) < 32'(ID_COUNT);
        present  = pos_rd[PW-1];
        slot     = pos_rd[SW-1:0];
        last     = r_count - CW'(1);
        last_s   = SW'(last);
        par_s    = (r_s - SW'(1)) >> 1;
        c1_x     = (XW'(r_s) << 1) + XW'(1);
        c2_x     = c1_x + XW'(1);
        lim_x    = XW'(r_count);
        c1_s     = SW'(c1_x);
        c2_s     = SW'(c2_x);
        best_is2 = r_has2 && (heap_rd.key > r_c1.key);
        best     = best_is2 ? heap_rd : r_c1;
        best_idx = best_is2 ? c2_s : c1_s;
        down_swap = best.key > r_elem.key;
        up_swap   = r_elem.key > heap_rd.key;
        // remove tries climbing when the entry did not sink
        down_end  = (r_moved || r_op != OP_REMOVE) ? S_WR : S_UP;
    end

    always_comb begin
        heap_we = 1'b0;
        heap_wa = r_s;
        heap_wd = r_elem;
        heap_ra = '0;
        pos_we  = 1'b0;
        pos_wa  = IW'(r_elem.id);
        pos_wd  = {1'b1, r_s};
        pos_ra  = (r_state == S_IDLE) ? IW'(i_in_data.item_id) : IW'(r_id);
        case (r_state)
            S_CLR: begin
                pos_we = 1'b1;
                pos_wa = r_clr;
                pos_wd = '0;
            end
            S_DEC: begin
                heap_ra = (r_op == OP_POP) ? '0 : slot;
            end
            S_FA: begin
                heap_ra = last_s;
                pos_we  = 1'b1;
                pos_wa  = IW'(heap_rd.id);
                pos_wd  = '0;
            end
            S_DC1:  heap_ra = c1_s;
            S_DC2:  heap_ra = c2_s;
            S_DCMP: begin
                if (down_swap) begin
                    heap_we = 1'b1;
                    heap_wd = best;
                    pos_we  = 1'b1;
                    pos_wa  = IW'(best.id);
                end
            end
            S_UP:   heap_ra = par_s;
            S_UCMP: begin
                if (up_swap) begin
                    heap_we = 1'b1;
                    heap_wd = heap_rd;
                    pos_we  = 1'b1;
                    pos_wa  = IW'(heap_rd.id);
                end
            end
            S_WR: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (!i_out_stall && r_state != S_RESP) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + IW'(1);
                    if (r_clr == IW'(ID_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in_data.op;
                        r_id    <= i_in_data.item_id;
                        r_key   <= i_in_data.priority_req;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_status <= ST_OK;
                    r_sid    <= r_id;
                    r_skey   <= '0;
                    r_moved  <= 1'b0;
                    r_state  <= S_RESP;
                    case (r_op)
                        OP_PUSH: begin
                            if (!id_ok) begin
                                r_status <= ST_ABSENT;
                            end else if (present) begin
                                r_status <= ST_PRESENT;
                            end else if (32'(r_count) >= 32'(CAPACITY)) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_elem  <= '{id: r_id, key: r_key};
                                r_s     <= SW'(r_count);
                                r_count <= r_count + CW'(1);
                                r_state <= S_UP;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                r_status <= ST_EMPTY;
                            end else begin
                                r_s     <= '0;
                                r_state <= S_FA;
                            end
                        end
                        OP_REMOVE: begin
                            if (!id_ok || !present) begin
                                r_status <= ST_ABSENT;
                            end else begin
                                r_s     <= slot;
                                r_state <= S_FA;
                            end
                        end
                        default: ;
                    endcase
                end
                S_FA: begin
                    r_count <= last;
                    r_skey  <= heap_rd.key;
                    if (r_op == OP_POP) begin
                        r_sid <= heap_rd.id;
                    end
                    r_state <= (CW'(r_s) == last) ? S_RESP : S_FB;
                end
                S_FB: begin
                    r_elem  <= heap_rd;
                    r_state <= S_DC1;
                end
                S_DC1: begin
                    r_state <= (c1_x >= lim_x) ? down_end : S_DC2;
                end
                S_DC2: begin
                    r_c1    <= heap_rd;
                    r_has2  <= c2_x < lim_x;
                    r_state <= S_DCMP;
                end
                S_DCMP: begin
                    if (down_swap) begin
                        r_s     <= best_idx;
                        r_moved <= 1'b1;
                        r_state <= S_DC1;
                    end else begin
                        r_state <= down_end;
                    end
                end
                S_UP: begin
                    r_state <= (r_s == '0) ? S_WR : S_UCMP;
                end
                S_UCMP: begin
                    if (up_swap) begin
                        r_s     <= par_s;
                        r_state <= S_UP;
                    end else begin
                        r_state <= S_WR;
                    end
                end
                S_WR: r_state <= S_RESP;
                S_RESP: begin
                    if (!r_ov || !i_out_stall) begin
                        r_ov                 <= 1'b1;
                        r_out.status         <= r_status;
                        r_out.served_id      <= r_sid;
                        r_out.served_key     <= r_skey;
                        r_out.occupancy      <= OCC_W'(r_count);
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
endmodule

@@ rtl/ixh_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
module ixh_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wa,
    input  logic [WIDTH-1:0] i_wd,
    input  logic [AW-1:0]    i_ra,
    output logic [WIDTH-1:0] o_rd
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd <= r_mem[i_ra];
    end
endmodule

@@ rtl/ixh_chk.sv @@
// Port-level checks for the indexed max-heap, bound to the top level.
module ixh_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ixh_pkg::t_out_beat o_out_data
);
    import ixh_pkg::*;

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= ST_PRESENT)
        else $error("unknown status code");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_EMPTY |-> o_out_data.occupancy == '0)
        else $error("empty status with nonzero occupancy");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_FULL |-> o_out_data.occupancy != '0)
        else $error("full status with zero occupancy");
endmodule

bind indexed_max_heap ixh_chk u_ixh_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data(o_out_data)
);
